// File: design/sqvs_pkg.sv
// Shared types, constants and tables for the sprite quad vertex setup block.
package sqvs_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int ANGLE_LIFT   = 24 - ANGLE_BITS;
    localparam int CORDIC_STEPS = 16;
    localparam int XY_W         = 20;
    localparam int Z_W          = 25;
    localparam int CS_W         = 18;
    localparam int NUM_W        = 40;
    localparam int DEN_W        = 21;
    localparam int OUT_W        = 16;
    localparam int CFG_W        = 13;
    localparam int CFG_IDX_W    = 3;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(39797);

    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050,
        25'sd166669,  25'sd83416,   25'sd41718,  25'sd20860,
        25'sd10430,   25'sd5215,    25'sd2608,   25'sd1304,
        25'sd652,     25'sd326,     25'sd163,    25'sd81
    };

    // dividend offsets: rounding bias, the 2^15 quotient bias of signed outputs and a 2^14 NDC offset
    localparam logic [NUM_W-1:0] KX_MUL = NUM_W'(64 * 32769);
    localparam logic [NUM_W-1:0] KY_MUL = NUM_W'(64 * 98305);

    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_W  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_H  = 3'd3;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    typedef struct packed {
        logic [1:0]        k;
        logic signed [15:0] dl;
        logic signed [15:0] dt;
        logic [15:0]       dw;
        logic [15:0]       dh;
        logic [15:0]       ang;
        logic [15:0]       sl;
        logic [15:0]       st;
        logic [15:0]       sw;
        logic [15:0]       sh;
        logic [31:0]       color;
    } t_vtx;

    typedef struct packed {
        logic [CFG_W-1:0] vp_w;
        logic [CFG_W-1:0] vp_h;
        logic [CFG_W-1:0] tex_w;
        logic [CFG_W-1:0] tex_h;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       k;
        logic [OUT_W-1:0] ndc_x;
        logic [OUT_W-1:0] ndc_y;
        logic [OUT_W-1:0] tex_u;
        logic [OUT_W-1:0] tex_v;
        logic [31:0]      color;
    } t_vout;

    typedef struct packed {
        logic [1:0]  k;
        logic [31:0] color;
    } t_side;

endpackage

// File: design/sqvs_div.sv
// Pipelined restoring divider with saturating 16-bit quotient.
module sqvs_div import sqvs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    input  logic                    i_signed,
    output logic [OUT_W-1:0]        o_q
);

    logic [NUM_W-1:0] r_rem  [0:OUT_W];
    logic [DEN_W-1:0] r_den  [0:OUT_W];
    logic [OUT_W-1:0] r_q    [0:OUT_W];
    logic             r_neg  [0:OUT_W];
    logic             r_over [0:OUT_W];
    logic [OUT_W-1:0] w_q;

    // negative dividend floors to zero, quotient past 16 bits saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0]  <= i_num[NUM_W-1];
            r_over[0] <= !i_num[NUM_W-1] &&
                         (unsigned'(i_num) >= (NUM_W'(i_den) << OUT_W));
            r_rem[0]  <= i_num[NUM_W-1] ? '0 : unsigned'(i_num);
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
        end
    end

    for (genvar i = 0; i < OUT_W; i++) begin : g_step
        localparam int SH = OUT_W - 1 - i;
        logic [NUM_W:0] w_trial;
        assign w_trial = {1'b0, r_rem[i]} - ((NUM_W+1)'(r_den[i]) << SH);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1]  <= w_trial[NUM_W] ? r_rem[i] : w_trial[NUM_W-1:0];
                r_q[i+1]    <= w_trial[NUM_W] ? r_q[i] : (r_q[i] | (OUT_W'(1) << SH));
                r_den[i+1]  <= r_den[i];
                r_neg[i+1]  <= r_neg[i];
                r_over[i+1] <= r_over[i];
            end
        end
    end

    always_comb begin
        if (r_neg[OUT_W]) begin
            w_q = '0;
        end else if (r_over[OUT_W]) begin
            w_q = '1;
        end else begin
            w_q = r_q[OUT_W];
        end
    end

    // signed results carry a 2^15 bias
    assign o_q = i_signed ? {~w_q[OUT_W-1], w_q[OUT_W-2:0]} : w_q;

endmodule

// File: design/sqvs_cordic.sv
// Pipelined CORDIC: cosine and sine of the sprite angle, one stage per step.
module sqvs_cordic import sqvs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_vtx                   i_vtx,
    output logic                   o_valid,
    output t_vtx                   o_vtx,
    output logic signed [CS_W-1:0] o_cos,
    output logic signed [CS_W-1:0] o_sin
);

    logic signed [XY_W-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_z    [0:CORDIC_STEPS];
    logic [1:0]             r_quad [0:CORDIC_STEPS];
    t_vtx                   r_vtx  [0:CORDIC_STEPS];
    logic                   r_vld  [0:CORDIC_STEPS];
    logic [23:0]            w_ph;
    logic [23:0]            w_rot;
    logic signed [CS_W-1:0] r_cos, r_sin;
    t_vtx                   r_vtx_out;
    logic                   r_vld_out;

    // fold the phase into [-45, 45) degrees plus a quadrant
    assign w_ph  = 24'({8'b0, i_vtx.ang} << ANGLE_LIFT);
    assign w_rot = w_ph + 24'h200000;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad[0] <= w_rot[23:22];
            r_z[0]    <= $signed({3'b0, w_rot[21:0]}) - 25'sd2097152;
            r_x[0]    <= CORDIC_GAIN;
            r_y[0]    <= '0;
            r_vtx[0]  <= i_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic signed [XY_W-1:0] w_xs, w_ys;
        assign w_xs = r_x[i] >>> i;
        assign w_ys = r_y[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - w_ys;
                    r_y[i+1] <= r_y[i] + w_xs;
                    r_z[i+1] <= r_z[i] - ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i] + w_ys;
                    r_y[i+1] <= r_y[i] - w_xs;
                    r_z[i+1] <= r_z[i] + ATAN_TAB[i];
                end
                r_quad[i+1] <= r_quad[i];
                r_vtx[i+1]  <= r_vtx[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_quad[CORDIC_STEPS])
                2'd0: begin
                    r_cos <= CS_W'(r_x[CORDIC_STEPS]);
                    r_sin <= CS_W'(r_y[CORDIC_STEPS]);
                end
                2'd1: begin
                    r_cos <= CS_W'(-r_y[CORDIC_STEPS]);
                    r_sin <= CS_W'(r_x[CORDIC_STEPS]);
                end
                2'd2: begin
                    r_cos <= CS_W'(-r_x[CORDIC_STEPS]);
                    r_sin <= CS_W'(-r_y[CORDIC_STEPS]);
                end
                default: begin
                    r_cos <= CS_W'(r_y[CORDIC_STEPS]);
                    r_sin <= CS_W'(-r_x[CORDIC_STEPS]);
                end
            endcase
            r_vtx_out <= r_vtx[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_out <= 1'b0;
        end else if (i_en) begin
            r_vld_out <= r_vld[CORDIC_STEPS];
        end
    end

    assign o_valid = r_vld_out;
    assign o_vtx   = r_vtx_out;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

// File: design/sqvs_map.sv
// Corner rotation, NDC and texture mapping with four pipelined dividers.
module sqvs_map import sqvs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_vtx                   i_vtx,
    input  logic signed [CS_W-1:0] i_cos,
    input  logic signed [CS_W-1:0] i_sin,
    input  t_cfg                   i_cfg,
    output logic                   o_valid,
    output t_vout                  o_vout
);

    localparam int DIV_LAT = OUT_W + 1;

    logic signed [17:0] w_ox, w_oy;
    logic [CFG_W-1:0]   w_vw, w_vh, w_tw, w_th;

    // stage A: products
    logic signed [35:0] r_a_pcx, r_a_psy, r_a_psx, r_a_pcy;
    logic signed [17:0] r_a_sx, r_a_sy;
    t_vtx               r_a_vtx;
    logic               r_a_vld;

    // stage B: rotated positions and source edges
    logic signed [NUM_W-1:0] r_b_px, r_b_py;
    logic [16:0]             r_b_tu, r_b_tv;
    t_side                   r_b_sd;
    logic                    r_b_vld;

    // stage C: dividends and divisors
    logic signed [NUM_W-1:0] r_c_nx, r_c_ny, r_c_nu, r_c_nv;
    logic [DEN_W-1:0]        r_c_dx, r_c_dy, r_c_du, r_c_dv;

    t_side r_sd  [0:DIV_LAT];
    logic  r_vld [0:DIV_LAT];

    logic [OUT_W-1:0] w_qx, w_qy, w_qu, w_qv;

    assign w_vw = (i_cfg.vp_w  == '0) ? CFG_W'(1) : i_cfg.vp_w;
    assign w_vh = (i_cfg.vp_h  == '0) ? CFG_W'(1) : i_cfg.vp_h;
    assign w_tw = (i_cfg.tex_w == '0) ? CFG_W'(1) : i_cfg.tex_w;
    assign w_th = (i_cfg.tex_h == '0) ? CFG_W'(1) : i_cfg.tex_h;

    // half-size offsets in Q.5 are the full size in Q.4
    assign w_ox = i_vtx.k[0] ? $signed({2'b0, i_vtx.dw}) : -$signed({2'b0, i_vtx.dw});
    assign w_oy = i_vtx.k[1] ? $signed({2'b0, i_vtx.dh}) : -$signed({2'b0, i_vtx.dh});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pcx <= i_cos * w_ox;
            r_a_psy <= i_sin * w_oy;
            r_a_psx <= i_sin * w_ox;
            r_a_pcy <= i_cos * w_oy;
            r_a_sx  <= (18'(i_vtx.dl) <<< 1) + $signed({2'b0, i_vtx.dw});
            r_a_sy  <= (18'(i_vtx.dt) <<< 1) + $signed({2'b0, i_vtx.dh});
            r_a_vtx <= i_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_px <= (NUM_W'(r_a_sx) <<< 16) + NUM_W'(r_a_pcx) - NUM_W'(r_a_psy);
            r_b_py <= (NUM_W'(r_a_sy) <<< 16) + NUM_W'(r_a_psx) + NUM_W'(r_a_pcy);
            r_b_tu <= 17'(r_a_vtx.sl) + (r_a_vtx.k[0] ? 17'(r_a_vtx.sw) : 17'd0);
            r_b_tv <= 17'(r_a_vtx.st) + (r_a_vtx.k[1] ? 17'(r_a_vtx.sh) : 17'd0);
            r_b_sd <= '{k: r_a_vtx.k, color: r_a_vtx.color};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_nx <= (r_b_px <<< 1) + $signed(NUM_W'(w_vw) * KX_MUL);
            r_c_ny <= $signed(NUM_W'(w_vh) * KY_MUL) - (r_b_py <<< 1);
            r_c_nu <= $signed(NUM_W'({r_b_tu, 9'b0}) + NUM_W'(w_tw));
            r_c_nv <= $signed(NUM_W'({r_b_tv, 9'b0}) + NUM_W'(w_th));
            r_c_dx <= DEN_W'({w_vw, 7'b0});
            r_c_dy <= DEN_W'({w_vh, 7'b0});
            r_c_du <= DEN_W'({w_tw, 1'b0});
            r_c_dv <= DEN_W'({w_th, 1'b0});
            r_sd[0] <= r_b_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_a_vld  <= i_valid;
            r_b_vld  <= r_a_vld;
            r_vld[0] <= r_b_vld;
        end
    end

    for (genvar i = 0; i < DIV_LAT; i++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[i+1] <= r_sd[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end
    end

    sqvs_div u_div_x (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_c_nx), .i_den(r_c_dx),
        .i_signed(1'b1), .o_q(w_qx)
    );
    sqvs_div u_div_y (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_c_ny), .i_den(r_c_dy),
        .i_signed(1'b1), .o_q(w_qy)
    );
    sqvs_div u_div_u (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_c_nu), .i_den(r_c_du),
        .i_signed(1'b0), .o_q(w_qu)
    );
    sqvs_div u_div_v (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_c_nv), .i_den(r_c_dv),
        .i_signed(1'b0), .o_q(w_qv)
    );

    assign o_valid = r_vld[DIV_LAT];
    assign o_vout  = '{k: r_sd[DIV_LAT].k, ndc_x: w_qx, ndc_y: w_qy,
                       tex_u: w_qu, tex_v: w_qv, color: r_sd[DIV_LAT].color};

endmodule

// File: design/sprite_quad_vertex_setup.sv
// Top level of the sprite quad vertex setup block.
//
// Usage:
//   s_axis carries one sprite request per transaction; m_axis returns four
//   vertex transactions per request (left-top, right-top, left-bottom,
//   right-bottom), the fourth with tlast set. The cfg channel writes the
//   viewport and texture sizes; it is always ready and should only be used
//   while no request is in flight.
//   Vertices leave m_axis one per cycle while the pipeline moves. A new
//   request is taken when none is held or as the held one issues its
//   last corner; the corner expander issues one vertex per cycle, unless
//   stalled, into a single 39-stage pipeline (CORDIC entry, 16 steps and quadrant
//   fix, three multiply/add stages, four 17-stage restoring dividers, output register).
//   Reset: synchronous, active low; clears all valid bits and loads the
//   default sizes (1280x720 viewport, 256x256 texture).
//   Back-pressure: when the output register holds an untaken vertex and the
//   pipeline's last stage is full, the whole pipeline freezes; bubbles keep
//   moving otherwise. No transaction is dropped or repeated.
module sprite_quad_vertex_setup import sqvs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // dest_left, dest_top, dest_width, dest_height, turn_angle,
    // src_left, src_top, src_width, src_height, tint_rgba (lowest first)
    input  logic [175:0]         s_axis_tdata,
    // vertex stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // ndc_x, ndc_y, tex_u, tex_v, vertex_color (lowest first)
    output logic [95:0]          m_axis_tdata,
    // corner_index
    output logic [1:0]           m_axis_tuser,
    // final_corner
    output logic                 m_axis_tlast,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg  r_cfg;
    t_vtx  r_vtx;
    logic  r_v;
    logic  w_en;
    logic  w_take;
    t_vtx  w_in;

    logic                   w_cor_vld;
    t_vtx                   w_cor_vtx;
    logic signed [CS_W-1:0] w_cos, w_sin;
    logic                   w_map_vld;
    t_vout                  w_map_out;

    logic  r_o_vld;
    t_vout r_o;

    // config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{vp_w: CFG_W'(1280), vp_h: CFG_W'(720),
                       tex_w: CFG_W'(256), tex_h: CFG_W'(256)};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VIEWPORT_W: r_cfg.vp_w  <= i_cfg_data;
                REG_VIEWPORT_H: r_cfg.vp_h  <= i_cfg_data;
                REG_TEXTURE_W:  r_cfg.tex_w <= i_cfg_data;
                REG_TEXTURE_H:  r_cfg.tex_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline moves unless a full last stage meets a stalled output register
    assign w_en = !w_map_vld || !r_o_vld || m_axis_tready;

    // corner expander: holds one request, issues a corner per cycle unless stalled
    assign s_axis_tready = w_en && (!r_v || r_vtx.k == CORNER_LAST);
    assign w_take        = s_axis_tvalid && s_axis_tready;

    assign w_in = '{k: CORNER_FIRST,
                    dl: s_axis_tdata[15:0],    dt: s_axis_tdata[31:16],
                    dw: s_axis_tdata[47:32],   dh: s_axis_tdata[63:48],
                    ang: s_axis_tdata[79:64],  sl: s_axis_tdata[95:80],
                    st: s_axis_tdata[111:96],  sw: s_axis_tdata[127:112],
                    sh: s_axis_tdata[143:128], color: s_axis_tdata[175:144]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            if (r_v && r_vtx.k != CORNER_LAST) begin
                r_v <= 1'b1;
            end else begin
                r_v <= w_take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_vtx <= w_in;
        end else if (w_en && r_v) begin
            r_vtx.k <= r_vtx.k + 2'd1;
        end
    end

    sqvs_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v),
        .i_vtx   (r_vtx),
        .o_valid (w_cor_vld),
        .o_vtx   (w_cor_vtx),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    sqvs_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cor_vld),
        .i_vtx   (w_cor_vtx),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .i_cfg   (r_cfg),
        .o_valid (w_map_vld),
        .o_vout  (w_map_out)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (!r_o_vld || m_axis_tready) begin
            r_o_vld <= w_map_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_o_vld || m_axis_tready) && w_map_vld) begin
            r_o <= w_map_out;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {r_o.color, r_o.tex_v, r_o.tex_u, r_o.ndc_y, r_o.ndc_x};
    assign m_axis_tuser  = r_o.k;
    assign m_axis_tlast  = (r_o.k == CORNER_LAST);

`ifndef SYNTHESIS
    a_last_on_corner3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == CORNER_LAST)))
        else $error("tlast not aligned with last corner");

    a_take_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!r_v || r_vtx.k == CORNER_LAST))
        else $error("request taken while corners still pending");

    a_expander_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v && !w_en) |=> (r_v && $stable(r_vtx.k)))
        else $error("corner expander moved during stall");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the sprite quad vertex setup block.
module tb_top import sqvs_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_STALL_CYCLES = 200;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // one queued vertex expectation
    typedef struct {
        logic [1:0]  corner;
        logic [15:0] ndc_x;
        logic [15:0] ndc_y;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic [31:0] color;
        logic        last;
    } t_vertex;

    typedef struct {
        logic [15:0] dl, dt, dw, dh, ang, sl, st, sw, sh;
        logic [31:0] tint;
    } t_sprite;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [175:0]         s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [95:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    sprite_quad_vertex_setup dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor's copy of the size registers
    logic [12:0] vp_w = 13'd1280, vp_h = 13'd720, tx_w = 13'd256, tx_h = 13'd256;

    t_vertex expected_vertices[$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      idle_enable = 1'b1;   // random gaps on both sides
    int      hold_off = 0;         // receiver stall, in cycles
    int      stall_asks = 0;       // long stalls asked for by a test
    int      stall_done = 0;       // long stalls started by the receiver

    // floor(n/d + 1/2) with signed operands, d > 0
    function automatic longint div_round(longint n, longint d);
        longint num, den, q;
        num = 2 * n + d;
        den = 2 * d;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    function automatic logic [15:0] clamp_s16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [15:0] clamp_u16(longint v);
        if (v > 65535) v = 65535;
        if (v < 0) v = 0;
        return v[15:0];
    endfunction

    // cosine and sine in Q16 from a 16-step shift-add rotation
    task automatic rotation_terms(input logic [15:0] angle, output longint c, output longint s);
        longint atan_steps[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                   41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        logic [23:0] phase;
        logic [23:0] folded;
        logic [1:0]  quadrant;
        longint x, y, z, xs, ys;
        phase = {angle, 8'd0};
        folded = phase + 24'h200000;
        quadrant = folded[23:22];
        z = longint'(folded[21:0]) - 64'sh200000;
        x = 39797;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_steps[i];
            end else begin
                x += ys; y -= xs; z += atan_steps[i];
            end
        end
        case (quadrant)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // push the four expected vertices of one sprite
    task automatic predict_quad(input t_sprite sp);
        longint dvx, dvy, tw, th, cx, cy, c, s, ox, oy, px, py, tx, ty;
        t_vertex v;
        dvx = longint'(vp_w == 0 ? 13'd1 : vp_w) * 64;
        dvy = longint'(vp_h == 0 ? 13'd1 : vp_h) * 64;
        tw = (tx_w == 0) ? 1 : tx_w;
        th = (tx_h == 0) ? 1 : tx_h;
        cx = (2 * longint'($signed(sp.dl)) + longint'(sp.dw)) * 65536;
        cy = (2 * longint'($signed(sp.dt)) + longint'(sp.dh)) * 65536;
        rotation_terms(sp.ang, c, s);
        for (int k = 0; k < 4; k++) begin
            ox = k[0] ? longint'(sp.dw) : -longint'(sp.dw);
            oy = k[1] ? longint'(sp.dh) : -longint'(sp.dh);
            px = cx + c * ox - s * oy;
            py = cy + s * ox + c * oy;
            tx = k[0] ? longint'(sp.sl) + longint'(sp.sw) : longint'(sp.sl);
            ty = k[1] ? longint'(sp.st) + longint'(sp.sh) : longint'(sp.st);
            v.corner = k[1:0];
            v.ndc_x = clamp_s16(div_round(px - 16384 * dvx, dvx));
            v.ndc_y = clamp_s16(div_round(16384 * dvy - py, dvy));
            v.tex_u = clamp_u16(div_round(tx * 256, tw));
            v.tex_v = clamp_u16(div_round(ty * 256, th));
            v.color = sp.tint;
            v.last = (k == 3);
            expected_vertices.push_back(v);
        end
    endtask

    // send one sprite request, sometimes after a random gap when idling is on;
    // tvalid stays high afterwards so requests can follow back to back
    task automatic send_sprite(input t_sprite sp);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tdata <= {sp.tint, sp.sh, sp.sw, sp.st, sp.sl, sp.ang,
                         sp.dh, sp.dw, sp.dt, sp.dl};
        s_axis_tvalid <= 1'b1;
        predict_quad(sp);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] value);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_VIEWPORT_W: vp_w = value;
            REG_VIEWPORT_H: vp_h = value;
            REG_TEXTURE_W:  tx_w = value;
            REG_TEXTURE_H:  tx_h = value;
            default: ;
        endcase
    endtask

    // stop offering, wait until every vertex has arrived, plus settle time
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [12:0] w, h, t_w, t_h);
        drain_pipeline();
        write_size(REG_VIEWPORT_W, w);
        write_size(REG_VIEWPORT_H, h);
        write_size(REG_TEXTURE_W, t_w);
        write_size(REG_TEXTURE_H, t_h);
    endtask

    function automatic t_sprite random_sprite();
        t_sprite sp;
        sp.dl = 16'($urandom); sp.dt = 16'($urandom);
        sp.dw = 16'($urandom); sp.dh = 16'($urandom);
        sp.ang = 16'($urandom); sp.sl = 16'($urandom); sp.st = 16'($urandom);
        sp.sw = 16'($urandom); sp.sh = 16'($urandom); sp.tint = $urandom;
        // mostly on-screen sprites so the outputs rarely clip
        if ($urandom_range(0, 3) != 0) begin
            sp.dl = 16'($urandom_range(0, 1280 * 16)) - 16'd2000;
            sp.dt = 16'($urandom_range(0, 720 * 16)) - 16'd2000;
            sp.dw = 16'($urandom_range(0, 4096));
            sp.dh = 16'($urandom_range(0, 4096));
            sp.sl = 16'($urandom_range(0, 4096));
            sp.st = 16'($urandom_range(0, 4096));
            sp.sw = 16'($urandom_range(0, 4096));
            sp.sh = 16'($urandom_range(0, 4096));
        end
        return sp;
    endfunction

    // edges of the fields, cardinal and odd angles
    task automatic test_directed();
        t_sprite sp;
        logic [15:0] angles[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                   16'h2000, 16'hE000, 16'h1FFF, 16'hFFFF};
        foreach (angles[i]) begin
            sp = '{16'd1600, 16'd800, 16'd320, 16'd160, angles[i],
                   16'd0, 16'd0, 16'd512, 16'd256, 32'h11223344};
            send_sprite(sp);
        end
        sp = '{16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF};
        send_sprite(sp);
        sp = '{16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h5555,
               16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h00000000};
        send_sprite(sp);
        sp = '{16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555, 16'h9999,
               16'h5555, 16'hAAAA, 16'h1234, 16'h4321, 32'hA5A55A5A};
        send_sprite(sp);
    endtask

    // extreme and zero divisors, and values above the nominal range
    task automatic test_size_settings();
        set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
        for (int i = 0; i < 4; i++) send_sprite(random_sprite());
        set_sizes(13'd0, 13'd0, 13'd0, 13'd0);
        for (int i = 0; i < 4; i++) send_sprite(random_sprite());
        set_sizes(13'd4096, 13'd4096, 13'd4096, 13'd4096);
        for (int i = 0; i < 4; i++) send_sprite(random_sprite());
        set_sizes(13'h1FFF, 13'd5000, 13'd8191, 13'd4097);
        for (int i = 0; i < 4; i++) send_sprite(random_sprite());
        // unused register index leaves all sizes untouched
        drain_pipeline();
        write_size(REG_SPARE_A, 13'd7);
        write_size(REG_SPARE_B, 13'd3);
        for (int i = 0; i < 3; i++) send_sprite(random_sprite());
    endtask

    // receiver stalls long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        set_sizes(13'd1280, 13'd720, 13'd256, 13'd256);
        stall_asks++;
        for (int i = 0; i < 30; i++) send_sprite(random_sprite());
    endtask

    task automatic test_random();
        logic [12:0] w, h, t_w, t_h;
        for (int phase = 0; phase < 4; phase++) begin
            w = 13'($urandom_range(1, 4096)); h = 13'($urandom_range(1, 4096));
            t_w = 13'($urandom_range(1, 4096)); t_h = 13'($urandom_range(1, 4096));
            set_sizes(w, h, t_w, t_h);
            if (phase == 3) idle_enable = 1'b0;   // run flat out at the end
            for (int i = 0; i < 60; i++) send_sprite(random_sprite());
        end
    endtask

    // receiver ready: random gaps, or a long counted hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_done != stall_asks) begin
            m_axis_tready <= 1'b0;
            hold_off <= LONG_STALL_CYCLES;
            stall_done <= stall_asks;
        end else if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= $urandom_range(0, 11);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each vertex transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_vertices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex: tdata=%h tuser=%0d tlast=%b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = expected_vertices.pop_front();
                if (m_axis_tuser !== want.corner || m_axis_tdata[15:0] !== want.ndc_x ||
                    m_axis_tdata[31:16] !== want.ndc_y || m_axis_tdata[47:32] !== want.tex_u ||
                    m_axis_tdata[63:48] !== want.tex_v || m_axis_tdata[95:64] !== want.color ||
                    m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("vertex mismatch: exp corner=%0d x=%h y=%h u=%h v=%h col=%h last=%b",
                                 want.corner, want.ndc_x, want.ndc_y, want.tex_u,
                                 want.tex_v, want.color, want.last);
                        $display("                 got corner=%0d x=%h y=%h u=%h v=%h col=%h last=%b",
                                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                                 m_axis_tdata[47:32], m_axis_tdata[63:48],
                                 m_axis_tdata[95:64], m_axis_tlast);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_size_settings();
        test_backpressure();
        test_random();
        drain_pipeline();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
